// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for RTL files that check their own behavior; only the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, disabled while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/cau_pkg.sv -----
// Shared types and constants of the complex arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
package cau_pkg;

  localparam int unsigned DataWidthDef = 16;
  localparam int unsigned FracBitsDef  = 8;
  localparam int unsigned OpWidth      = 2;

  typedef enum logic [OpWidth-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  // Control that travels alongside the operands of one item.
  typedef struct packed {
    op_e  op;
    logic dz;
  } ctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/cau_prod.sv -----
// Product and combine stages: partial products, then sign and magnitude of each part.
`timescale 1ns / 1ps
`default_nettype none
module cau_prod #(
  parameter int unsigned DATA_WIDTH = cau_pkg::DataWidthDef,
  parameter int unsigned FRAC_BITS  = cau_pkg::FracBitsDef
) (
  input  wire                          clk_i,
  input  wire                          en_i,
  input  cau_pkg::op_e                 op_i,
  input  wire signed [DATA_WIDTH-1:0]  a_re_i,
  input  wire signed [DATA_WIDTH-1:0]  a_im_i,
  input  wire signed [DATA_WIDTH-1:0]  b_re_i,
  input  wire signed [DATA_WIDTH-1:0]  b_im_i,
  output cau_pkg::ctl_t                ctl_o,
  output logic                         re_neg_o,
  output logic [2*DATA_WIDTH-1:0]      re_mag_o,
  output logic                         im_neg_o,
  output logic [2*DATA_WIDTH-1:0]      im_mag_o,
  output logic [2*DATA_WIDTH-1:0]      den_o
);

  localparam int unsigned PW = 2 * DATA_WIDTH;

  cau_pkg::op_e          op_q;
  logic signed [PW-1:0]  p_rr_q, p_ii_q, p_ri_q, p_ir_q, p_br_q, p_bi_q;
  logic signed [DATA_WIDTH:0] sum_re_q, sum_im_q, sum_re_d, sum_im_d;

  always_comb begin
    if (op_i == cau_pkg::OP_SUB) begin
      sum_re_d = {a_re_i[DATA_WIDTH-1], a_re_i} - {b_re_i[DATA_WIDTH-1], b_re_i};
      sum_im_d = {a_im_i[DATA_WIDTH-1], a_im_i} - {b_im_i[DATA_WIDTH-1], b_im_i};
    end else begin
      sum_re_d = {a_re_i[DATA_WIDTH-1], a_re_i} + {b_re_i[DATA_WIDTH-1], b_re_i};
      sum_im_d = {a_im_i[DATA_WIDTH-1], a_im_i} + {b_im_i[DATA_WIDTH-1], b_im_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q     <= op_i;
      p_rr_q   <= a_re_i * b_re_i;
      p_ii_q   <= a_im_i * b_im_i;
      p_ri_q   <= a_re_i * b_im_i;
      p_ir_q   <= a_im_i * b_re_i;
      p_br_q   <= b_re_i * b_re_i;
      p_bi_q   <= b_im_i * b_im_i;
      sum_re_q <= sum_re_d;
      sum_im_q <= sum_im_d;
    end
  end

  logic signed [PW:0] s_re, s_im, n_re, n_im;
  logic [PW-1:0]      m_re, m_im, den_d;
  cau_pkg::ctl_t      ctl_d;

  always_comb begin
    case (op_q)
      cau_pkg::OP_MUL: begin
        s_re = {p_rr_q[PW-1], p_rr_q} - {p_ii_q[PW-1], p_ii_q};
        s_im = {p_ri_q[PW-1], p_ri_q} + {p_ir_q[PW-1], p_ir_q};
      end
      cau_pkg::OP_DIV: begin
        s_re = {p_rr_q[PW-1], p_rr_q} + {p_ii_q[PW-1], p_ii_q};
        s_im = {p_ir_q[PW-1], p_ir_q} - {p_ri_q[PW-1], p_ri_q};
      end
      default: begin
        s_re = {{(PW-DATA_WIDTH){sum_re_q[DATA_WIDTH]}}, sum_re_q};
        s_im = {{(PW-DATA_WIDTH){sum_im_q[DATA_WIDTH]}}, sum_im_q};
      end
    endcase
    n_re = -s_re;
    n_im = -s_im;
    m_re = s_re[PW] ? n_re[PW-1:0] : s_re[PW-1:0];
    m_im = s_im[PW] ? n_im[PW-1:0] : s_im[PW-1:0];
    // A product keeps FRAC_BITS too many fraction bits; dropping them from the
    // magnitude rounds toward zero.
    if (op_q == cau_pkg::OP_MUL) begin
      m_re = m_re >> FRAC_BITS;
      m_im = m_im >> FRAC_BITS;
    end
    den_d     = p_br_q[PW-1:0] + p_bi_q[PW-1:0];
    ctl_d.op  = op_q;
    ctl_d.dz  = (op_q == cau_pkg::OP_DIV) && (den_d == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_o    <= ctl_d;
      re_neg_o <= s_re[PW];
      re_mag_o <= m_re;
      im_neg_o <= s_im[PW];
      im_mag_o <= m_im;
      den_o    <= den_d;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/cau_div.sv -----
// Restoring divider, one quotient bit per pipeline stage, with range check up front.
`timescale 1ns / 1ps
`default_nettype none
module cau_div #(
  parameter int unsigned DATA_WIDTH = cau_pkg::DataWidthDef,
  parameter int unsigned FRAC_BITS  = cau_pkg::FracBitsDef
) (
  input  wire                        clk_i,
  input  wire                        en_i,
  input  wire  [2*DATA_WIDTH-1:0]    num_i,
  input  wire  [2*DATA_WIDTH-1:0]    den_i,
  output logic [DATA_WIDTH-1:0]      quo_o,
  output logic                       ovf_o
);

  localparam int unsigned RW = 2 * DATA_WIDTH + FRAC_BITS;
  localparam int unsigned CW = 3 * DATA_WIDTH + FRAC_BITS;

  logic [RW-1:0]         rem_q [DATA_WIDTH+1];
  logic [2*DATA_WIDTH-1:0] den_q [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] quo_q [DATA_WIDTH+1];
  logic                  ovf_q [DATA_WIDTH+1];

  logic [RW-1:0] n_d;
  logic [CW-1:0] lim_d;

  always_comb begin
    n_d   = RW'(num_i) << FRAC_BITS;
    lim_d = CW'(den_i) << DATA_WIDTH;
  end

  // The quotient fits in DATA_WIDTH bits exactly when the scaled numerator is
  // below the divisor shifted by DATA_WIDTH; otherwise it saturates anyway.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= n_d;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= (CW'(n_d) >= lim_d);
    end
  end

  for (genvar s = 1; s <= DATA_WIDTH; s++) begin : g_step
    localparam int unsigned K = DATA_WIDTH - s;
    logic [CW-1:0] dsh, rx, diff;
    logic          take;
    always_comb begin
      dsh  = CW'(den_q[s-1]) << K;
      rx   = CW'(rem_q[s-1]);
      take = (rx >= dsh);
      diff = rx - dsh;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= take ? diff[RW-1:0] : rem_q[s-1];
        den_q[s] <= den_q[s-1];
        quo_q[s] <= quo_q[s-1] | (DATA_WIDTH'(take) << K);
        ovf_q[s] <= ovf_q[s-1];
      end
    end
  end

  assign quo_o = quo_q[DATA_WIDTH];
  assign ovf_o = ovf_q[DATA_WIDTH];

endmodule
`default_nettype wire

// ----- hw/rtl/complex_arithmetic_unit.sv -----
// Top level of the complex arithmetic unit: input stage, delay line, saturation and output.
//
//  Port group   Direction  tdata (low bit up)               tuser
//  s_axis       in         a_re, a_im, b_re, b_im           req_type
//  m_axis       out        res_re, res_im                   overflow, div_zero
//
// One item enters per cycle while the output is not stalled. The divider
// resolves one quotient bit per stage. Add, subtract and multiply ride the
// same pipeline so results leave in order.
// Reset clears only the valid bits. The whole pipeline holds while the output
// register holds an item that is not taken; s_axis_tready_o is low only then.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module complex_arithmetic_unit #(
  parameter int unsigned DATA_WIDTH = cau_pkg::DataWidthDef,
  parameter int unsigned FRAC_BITS  = cau_pkg::FracBitsDef,
  localparam int unsigned IN_W      = ((4 * DATA_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_W     = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  wire  [IN_W-1:0]    s_axis_tdata_i,   // a_re, a_im, b_re, b_im
  input  wire  [1:0]         s_axis_tuser_i,   // req_type
  output logic               m_axis_tvalid_o,
  input  wire                m_axis_tready_i,
  output logic [OUT_W-1:0]   m_axis_tdata_o,   // res_re, res_im
  output logic [1:0]         m_axis_tuser_o    // overflow, div_zero
);

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned PW = 2 * DATA_WIDTH;
  localparam int unsigned NV = W + 4;  // input stage, two product stages, W+1 divider stages

  logic en;
  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // Input stage.
  cau_pkg::op_e        op_q;
  logic signed [W-1:0] a_re_q, a_im_q, b_re_q, b_im_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      op_q   <= cau_pkg::op_e'(s_axis_tuser_i);
      a_re_q <= s_axis_tdata_i[W-1:0];
      a_im_q <= s_axis_tdata_i[2*W-1:W];
      b_re_q <= s_axis_tdata_i[3*W-1:2*W];
      b_im_q <= s_axis_tdata_i[4*W-1:3*W];
    end
  end

  logic [NV-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NV-2:0], s_axis_tvalid_i};
    end
  end

  cau_pkg::ctl_t p_ctl;
  logic          p_re_neg, p_im_neg;
  logic [PW-1:0] p_re_mag, p_im_mag, p_den;

  cau_prod #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_prod (
    .clk_i   (clk_i),
    .en_i    (en),
    .op_i    (op_q),
    .a_re_i  (a_re_q),
    .a_im_i  (a_im_q),
    .b_re_i  (b_re_q),
    .b_im_i  (b_im_q),
    .ctl_o   (p_ctl),
    .re_neg_o(p_re_neg),
    .re_mag_o(p_re_mag),
    .im_neg_o(p_im_neg),
    .im_mag_o(p_im_mag),
    .den_o   (p_den)
  );

  logic [W-1:0] q_re, q_im;
  logic         ovf_re, ovf_im;

  cau_div #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_re (
    .clk_i(clk_i), .en_i(en), .num_i(p_re_mag), .den_i(p_den),
    .quo_o(q_re), .ovf_o(ovf_re)
  );

  cau_div #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_im (
    .clk_i(clk_i), .en_i(en), .num_i(p_im_mag), .den_i(p_den),
    .quo_o(q_im), .ovf_o(ovf_im)
  );

  // Delay line that keeps the non-divide results aligned with the divider.
  cau_pkg::ctl_t dl_ctl_q    [W+1];
  logic          dl_re_neg_q [W+1];
  logic          dl_im_neg_q [W+1];
  logic [PW-1:0] dl_re_mag_q [W+1];
  logic [PW-1:0] dl_im_mag_q [W+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dl_ctl_q[0]    <= p_ctl;
      dl_re_neg_q[0] <= p_re_neg;
      dl_im_neg_q[0] <= p_im_neg;
      dl_re_mag_q[0] <= p_re_mag;
      dl_im_mag_q[0] <= p_im_mag;
      for (int i = 1; i <= W; i++) begin
        dl_ctl_q[i]    <= dl_ctl_q[i-1];
        dl_re_neg_q[i] <= dl_re_neg_q[i-1];
        dl_im_neg_q[i] <= dl_im_neg_q[i-1];
        dl_re_mag_q[i] <= dl_re_mag_q[i-1];
        dl_im_mag_q[i] <= dl_im_mag_q[i-1];
      end
    end
  end

  // Saturation stage. The divider hands its result to the same stage as the
  // other ops, taken from the last delay entry to match its latency.
  localparam logic [PW-1:0] HALF = PW'(1) << (W - 1);

  cau_pkg::ctl_t c;
  logic          neg_re, neg_im, ov_re, ov_im;
  logic [PW-1:0] fm_re, fm_im, ng_re, ng_im;
  logic [W-1:0]  res_re_d, res_im_d;

  always_comb begin
    c      = dl_ctl_q[W];
    neg_re = dl_re_neg_q[W];
    neg_im = dl_im_neg_q[W];
    if (c.op == cau_pkg::OP_DIV) begin
      fm_re = ovf_re ? (PW'(1) << W) : PW'(q_re);
      fm_im = ovf_im ? (PW'(1) << W) : PW'(q_im);
      if (c.dz) begin
        fm_re = '0;
        fm_im = '0;
      end
    end else begin
      fm_re = dl_re_mag_q[W];
      fm_im = dl_im_mag_q[W];
    end
    ng_re = -fm_re;
    ng_im = -fm_im;
    ov_re = neg_re ? (fm_re > HALF) : (fm_re > HALF - PW'(1));
    ov_im = neg_im ? (fm_im > HALF) : (fm_im > HALF - PW'(1));
    if (ov_re) begin
      res_re_d = neg_re ? HALF[W-1:0] : ~HALF[W-1:0];
    end else begin
      res_re_d = neg_re ? ng_re[W-1:0] : fm_re[W-1:0];
    end
    if (ov_im) begin
      res_im_d = neg_im ? HALF[W-1:0] : ~HALF[W-1:0];
    end else begin
      res_im_d = neg_im ? ng_im[W-1:0] : fm_im[W-1:0];
    end
  end

  logic [W-1:0] res_re_q, res_im_q;
  logic         ov_q, dz_q, out_vld_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_re_q <= res_re_d;
      res_im_q <= res_im_d;
      ov_q     <= ov_re || ov_im;
      dz_q     <= c.dz;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_q[NV-1];
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OUT_W'({res_im_q, res_re_q});
  assign m_axis_tuser_o  = {dz_q, ov_q};

  `ASSERT_IMPL(a_dz_zero, m_axis_tvalid_o && m_axis_tuser_o[1], (res_re_q == '0) && (res_im_q == '0) && !m_axis_tuser_o[0], "divide by zero must give zero without overflow")
  `ASSERT_CLK(a_ready, s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i), "input ready must follow output backpressure")
  `ASSERT_IMPL(a_hold, m_axis_tvalid_o && !m_axis_tready_i, ##1 m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled result must be held")

endmodule
`default_nettype wire

// ----- test/cau_checker.sv -----
// Checker of the complex arithmetic unit: predicts each result and compares it.
`timescale 1ns / 1ps
module cau_checker (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_valid_i,
  input  wire         s_ready_i,
  input  wire  [63:0] s_data_i,
  input  wire  [1:0]  s_user_i,
  input  wire         m_valid_i,
  input  wire         m_ready_i,
  input  wire  [31:0] m_data_i,
  input  wire  [1:0]  m_user_i,
  output int          fail_count_o,
  output int          pending_o
);
  import cau_pkg::*;

  typedef struct packed {
    logic [15:0] re;
    logic [15:0] im;
    logic        ovf;
    logic        dz;
  } cplx_res_t;

  cplx_res_t expected_q[$];

  // Clamp a wide signed value to 16 bits, noting saturation.
  function automatic logic [15:0] clamp16(input logic signed [63:0] v, inout logic ovf);
    if (v > 64'sd32767) begin
      ovf = 1'b1;
      return 16'h7fff;
    end
    if (v < -64'sd32768) begin
      ovf = 1'b1;
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  // Truncating division toward zero of num * 2^8 by den.
  function automatic logic signed [63:0] qdiv(input logic signed [63:0] num,
                                              input logic signed [63:0] den);
    logic [63:0] mag;
    mag = (num < 0) ? -num : num;
    mag = (mag << 8) / den;
    return (num < 0) ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic cplx_res_t compute_complex(input op_e op, input logic [63:0] d);
    logic signed [63:0] ar, ai, br, bi, rr, ri, den;
    logic signed [63:0] mr, mi;
    cplx_res_t r;
    ar = $signed(d[15:0]);
    ai = $signed(d[31:16]);
    br = $signed(d[47:32]);
    bi = $signed(d[63:48]);
    r = '0;
    case (op)
      OP_ADD: begin
        rr = ar + br;
        ri = ai + bi;
      end
      OP_SUB: begin
        rr = ar - br;
        ri = ai - bi;
      end
      OP_MUL: begin
        mr = ar * br - ai * bi;
        mi = ar * bi + ai * br;
        rr = (mr < 0) ? -((-mr) >>> 8) : (mr >>> 8);
        ri = (mi < 0) ? -((-mi) >>> 8) : (mi >>> 8);
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.dz = 1'b1;
          return r;
        end
        rr = qdiv(ar * br + ai * bi, den);
        ri = qdiv(ai * br - ar * bi, den);
      end
    endcase
    r.re = clamp16(rr, r.ovf);
    r.im = clamp16(ri, r.ovf);
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    cplx_res_t want, got;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (s_valid_i && s_ready_i)
        expected_q.push_back(compute_complex(op_e'(s_user_i), s_data_i));
      if (m_valid_i && m_ready_i) begin
        got = {m_data_i[15:0], m_data_i[31:16], m_user_i[0], m_user_i[1]};
        if (expected_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result %h", got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (want !== got) begin
            if (fail_count_o < 10)
              $display("mismatch: expected re=%h im=%h ovf=%b dz=%b, got re=%h im=%h ovf=%b dz=%b",
                       want.re, want.im, want.ovf, want.dz, got.re, got.im, got.ovf, got.dz);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

// ----- test/testbench.sv -----
// Stimulus and verdict for the complex arithmetic unit testbench.
`timescale 1ns / 1ps
module testbench;
  import cau_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [63:0] s_data = '0;
  logic [1:0]  s_user = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [31:0] m_data;
  logic [1:0]  m_user;
  int          fail_count, pending;
  int          send_idle_pct = 0, recv_stall_pct = 0;
  int          idle_cycles = 0;

  always #2 clk_i = ~clk_i;

  complex_arithmetic_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tuser_o(m_user)
  );

  cau_checker checker_inst (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_valid_i(s_valid), .s_ready_i(s_ready), .s_data_i(s_data), .s_user_i(s_user),
    .m_valid_i(m_valid), .m_ready_i(m_ready), .m_data_i(m_data), .m_user_i(m_user),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if (rst_ni) m_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles with no accepted item on either side.
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("testbench failed");
      $finish;
    end
  end

  function automatic logic [15:0] rand_part();
    case ($urandom_range(5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_op(input op_e op, input logic [15:0] ar, ai, br, bi);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= {bi, br, ai, ar};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] ar, ai, br, bi;
    op_e op;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: extremes, every operation, saturation, divide by zero.
    send_op(OP_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_op(OP_ADD, 16'h0100, 16'hff00, 16'h0200, 16'h0001);
    send_op(OP_SUB, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_op(OP_SUB, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_op(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_op(OP_MUL, 16'h7fff, 16'h0000, 16'h7fff, 16'h0000);
    send_op(OP_MUL, 16'hffff, 16'h0001, 16'h0001, 16'h0001);
    send_op(OP_MUL, 16'h0180, 16'hfe80, 16'h0100, 16'h0100);
    send_op(OP_DIV, 16'h0100, 16'h0100, 16'h0000, 16'h0000);
    send_op(OP_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_op(OP_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000);
    send_op(OP_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_op(OP_DIV, 16'h0100, 16'h0000, 16'h0300, 16'h0000);
    send_op(OP_DIV, 16'hff00, 16'h0200, 16'h0000, 16'h0300);
    send_op(OP_DIV, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_op(OP_DIV, 16'h8000, 16'h7fff, 16'h0001, 16'hffff);
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 3) ? 34 : 81) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 34 : 81) : 0;
      for (int n = 0; n < 110; n++) begin
        op = op_e'($urandom_range(3));
        ar = rand_part();
        ai = rand_part();
        br = rand_part();
        bi = rand_part();
        if (op == OP_DIV && $urandom_range(15) == 0) begin
          br = '0;
          bi = '0;
        end
        send_op(op, ar, ai, br, bi);
      end
    end
    s_valid <= 1'b0;
    recv_stall_pct = 0;
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/cau_pkg.sv
hw/rtl/cau_prod.sv
hw/rtl/cau_div.sv
hw/rtl/complex_arithmetic_unit.sv
test/cau_checker.sv
test/testbench.sv
